// File: rtl/hkrd_pkg.sv
// Package for the keyboard report differ: widths, sequencer codes and the microprogram.
`default_nettype none
package hkrd_pkg;

  localparam int KEY_SLOTS_DEFAULT = 6;
  localparam int INPUT_KEY_FIELDS  = 6;
  localparam int KEY_W             = 8;
  localparam int MOD_BITS          = 8;
  localparam int IN_DATA_W         = KEY_W + INPUT_KEY_FIELDS * KEY_W;
  localparam int OUT_DATA_W        = 24;

  // Step addresses of the microprogram.
  localparam logic [2:0] STEP_IDLE    = 3'd0;
  localparam logic [2:0] STEP_PRESS   = 3'd1;
  localparam logic [2:0] STEP_RELEASE = 3'd2;
  localparam logic [2:0] STEP_MODS    = 3'd3;
  localparam logic [2:0] STEP_FLUSH   = 3'd4;
  localparam logic [2:0] STEP_COMMIT  = 3'd5;

  // Datapath operation selected by one control word.
  typedef enum logic [2:0] {
    OP_WAIT,
    OP_PRESS,
    OP_RELEASE,
    OP_MODS,
    OP_FLUSH,
    OP_COMMIT
  } op_t;

  // One control word: the operation and the step that follows it.
  typedef struct packed {
    op_t        op;
    logic [2:0] next;
  } ucode_t;

  // Read-only microprogram. Loop steps repeat until their counter reaches its limit.
  function automatic ucode_t ucode_rom(input logic [2:0] addr);
    ucode_t w;
    unique case (addr)
      STEP_IDLE:    w = '{op: OP_WAIT,    next: STEP_PRESS};
      STEP_PRESS:   w = '{op: OP_PRESS,   next: STEP_RELEASE};
      STEP_RELEASE: w = '{op: OP_RELEASE, next: STEP_MODS};
      STEP_MODS:    w = '{op: OP_MODS,    next: STEP_FLUSH};
      STEP_FLUSH:   w = '{op: OP_FLUSH,   next: STEP_COMMIT};
      STEP_COMMIT:  w = '{op: OP_COMMIT,  next: STEP_IDLE};
      default:      w = '{op: OP_WAIT,    next: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: rtl/hkrd_slot_match.sv
// Parallel compare of one key code against every slot of a key set.
`default_nettype none
module hkrd_slot_match
  import hkrd_pkg::*;
#(
  parameter int KEY_SLOTS = KEY_SLOTS_DEFAULT
) (
  input  wire logic [KEY_SLOTS-1:0][KEY_W-1:0] slots,
  input  wire logic [KEY_W-1:0]                code,
  output logic                                 hit
);

  // One equality compare per slot, then an OR reduction.
  logic [KEY_SLOTS-1:0] eq;

  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      eq[i] = (slots[i] == code);
    end
  end

  assign hit = |eq;

endmodule
`default_nettype wire

// File: rtl/hid_keyboard_report_differ.sv
// Top level: keyboard report differ with a microcoded event sequencer.
// Run: an accepted key report passes press and release scans over every slot, a scan of the
// eight modifier bits, then flush and commit, and waits while the result side stalls; each event
// leaves when the next one is found, and the final one leaves at the flush step.
// Throughput: one report per run; a new report is taken only when the sequencer is idle.
// Reports that are not key reports, or arrive while disabled, are taken while idle and start no run.
// Reset clears the enable, the kept key slots and the kept modifier byte.
`default_nettype none
module hid_keyboard_report_differ
  import hkrd_pkg::*;
#(
  parameter int KEY_SLOTS = KEY_SLOTS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Configuration: device_enabled.
  input  wire logic                  cfg_wr_en,
  input  wire logic                  cfg_wr_data,
  // Input report.
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // modifier_bits, key_slot_0 .. key_slot_5
  input  wire logic                  s_axis_tuser,  // is_key_report
  // Output events.
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // event_kind, key_code, report_modifiers
  output logic                       m_axis_tuser,  // is_modifier
  output logic                       m_axis_tlast   // last_of_run
);

  localparam int KEY_IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int CNT_W     = (KEY_IDX_W > 3) ? KEY_IDX_W : 3;
  localparam logic [CNT_W-1:0] KEY_LAST = CNT_W'(KEY_SLOTS - 1);
  localparam logic [CNT_W-1:0] MOD_LAST = CNT_W'(MOD_BITS - 1);

  // Sequencer and kept state.
  logic [2:0]                      pc;
  logic [CNT_W-1:0]                cnt;
  logic                            device_enabled;
  logic [KEY_SLOTS-1:0][KEY_W-1:0] kept_keys;
  logic [KEY_W-1:0]                prev_mods;
  logic [KEY_SLOTS-1:0][KEY_W-1:0] now_keys;
  logic [KEY_W-1:0]                now_mods;

  // Pending event, held back one step so the final one can be marked.
  logic                            pend_valid;
  logic                            pend_kind;
  logic                            pend_mod;
  logic [KEY_W-1:0]                pend_code;
  logic [KEY_W-1:0]                pend_mods;

  // Output register.
  logic                            out_kind;
  logic [KEY_W-1:0]                out_code;
  logic [KEY_W-1:0]                out_mods;

  ucode_t                          uw;
  logic                            in_xfer;
  logic                            out_free;
  logic [KEY_IDX_W-1:0]            key_idx;
  logic [KEY_W-1:0]                key_now;
  logic [KEY_W-1:0]                key_prev;
  logic                            now_in_prev;
  logic                            prev_in_now;
  logic [KEY_W-1:0]                mods_changed;
  logic                            cand_hit;
  logic                            cand_kind;
  logic                            cand_mod;
  logic [KEY_W-1:0]                cand_code;
  logic [KEY_W-1:0]                cand_mods;
  logic                            stall;
  logic                            move;
  logic [CNT_W-1:0]                cnt_limit;
  logic [(KEY_SLOTS+INPUT_KEY_FIELDS)*KEY_W-1:0] slot_wide;

  assign uw            = ucode_rom(pc);
  assign s_axis_tready = (uw.op == OP_WAIT);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Slots beyond the input fields load as empty.
  assign slot_wide = {{(KEY_SLOTS*KEY_W){1'b0}}, s_axis_tdata[IN_DATA_W-1:KEY_W]};

  // Slot lookups for the current step.
  assign key_idx      = cnt[KEY_IDX_W-1:0];
  assign key_now      = now_keys[key_idx];
  assign key_prev     = kept_keys[key_idx];
  assign mods_changed = now_mods ^ prev_mods;

  hkrd_slot_match #(.KEY_SLOTS(KEY_SLOTS)) u_match_prev (
    .slots (kept_keys),
    .code  (key_now),
    .hit   (now_in_prev)
  );

  hkrd_slot_match #(.KEY_SLOTS(KEY_SLOTS)) u_match_now (
    .slots (now_keys),
    .code  (key_prev),
    .hit   (prev_in_now)
  );

  // Candidate event of the current step.
  always_comb begin
    cand_hit  = 1'b0;
    cand_kind = 1'b0;
    cand_mod  = 1'b0;
    cand_code = key_now;
    cand_mods = now_mods;
    cnt_limit = KEY_LAST;
    case (uw.op)
      OP_PRESS: begin
        cand_hit = (key_now != '0) && !now_in_prev;
      end
      OP_RELEASE: begin
        cand_hit  = (key_prev != '0) && !prev_in_now;
        cand_kind = 1'b1;
        cand_code = key_prev;
      end
      OP_MODS: begin
        cand_hit  = mods_changed[cnt[2:0]];
        cand_kind = !now_mods[cnt[2:0]];
        cand_mod  = 1'b1;
        cand_code = KEY_W'(cnt[2:0]);
        cand_mods = '0;
        cnt_limit = MOD_LAST;
      end
      default: begin
      end
    endcase
  end

  // A found event displaces the pending one, which needs a free output register.
  always_comb begin
    move  = 1'b0;
    stall = 1'b0;
    if (uw.op == OP_FLUSH) begin
      move  = pend_valid && out_free;
      stall = pend_valid && !out_free;
    end else if (cand_hit && pend_valid) begin
      move  = out_free;
      stall = !out_free;
    end
  end

  // Sequencer, kept state and event registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc             <= STEP_IDLE;
      cnt            <= '0;
      device_enabled <= 1'b0;
      kept_keys      <= '0;
      prev_mods      <= '0;
      pend_valid     <= 1'b0;
      m_axis_tvalid  <= 1'b0;
      m_axis_tlast   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        device_enabled <= cfg_wr_data;
      end

      // Output register: load on move, empty on transfer.
      if (move) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tlast  <= (uw.op == OP_FLUSH);
        out_kind      <= pend_kind;
        m_axis_tuser  <= pend_mod;
        out_code      <= pend_code;
        out_mods      <= pend_mods;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      // Pending event register.
      if (!stall && cand_hit) begin
        pend_valid <= 1'b1;
        pend_kind  <= cand_kind;
        pend_mod   <= cand_mod;
        pend_code  <= cand_code;
        pend_mods  <= cand_mods;
      end else if (move) begin
        pend_valid <= 1'b0;
      end

      // Step counter and jumps.
      case (uw.op)
        OP_WAIT: begin
          if (in_xfer && device_enabled && s_axis_tuser) begin
            now_mods <= s_axis_tdata[KEY_W-1:0];
            now_keys <= slot_wide[KEY_SLOTS*KEY_W-1:0];
            cnt      <= '0;
            pc       <= uw.next;
          end
        end
        OP_PRESS, OP_RELEASE, OP_MODS: begin
          if (!stall) begin
            if (cnt == cnt_limit) begin
              cnt <= '0;
              pc  <= uw.next;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        OP_FLUSH: begin
          if (!stall) begin
            pc <= uw.next;
          end
        end
        OP_COMMIT: begin
          kept_keys <= now_keys;
          prev_mods <= now_mods;
          pc        <= uw.next;
        end
        default: begin
          pc <= STEP_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tdata = {7'b0, out_mods, out_code, out_kind};

  // The pending event is always drained before the sequencer goes idle.
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !pend_valid)
    else $error("pending event left over while idle");

  // The commit step always returns to idle.
  a_commit_to_idle: assert property (@(posedge clk) disable iff (rst)
    (uw.op == OP_COMMIT) |=> s_axis_tready)
    else $error("commit did not return to idle");

  // The flush of a pending event produces the marked final event.
  a_flush_marks_last: assert property (@(posedge clk) disable iff (rst)
    (uw.op == OP_FLUSH && pend_valid && out_free) |=> (m_axis_tvalid && m_axis_tlast))
    else $error("final event not marked");

  // An ignored report leaves the sequencer idle.
  a_ignored_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !(device_enabled && s_axis_tuser)) |=> s_axis_tready)
    else $error("ignored report started a run");

  // A marked final event only comes from the flush step.
  a_last_from_flush: assert property (@(posedge clk) disable iff (rst)
    (move && uw.op != OP_FLUSH) |=> !m_axis_tlast)
    else $error("event marked final before the flush");

endmodule
`default_nettype wire
